[rtl/core/tspd_pkg.sv]
// ----------------------------------------------------------------------------
// tspd_pkg
// Types and constants shared by the time-signal pulse decoder clock.
// ----------------------------------------------------------------------------
package tspd_pkg;

   localparam int CNT_W  = 11;
   localparam int POS_W  = 6;
   localparam int SEC_W  = 6;
   localparam int MIN_W  = 6;
   localparam int HOUR_W = 5;

   localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

   localparam logic [CNT_W-1:0] GAP_RESET       = 11'd1500;
   localparam logic [CNT_W-1:0] ZERO_LOW_RESET  = 11'd90;
   localparam logic [CNT_W-1:0] ZERO_HIGH_RESET = 11'd100;
   localparam logic [CNT_W-1:0] ONE_LOW_RESET   = 11'd100;
   localparam logic [CNT_W-1:0] ONE_HIGH_RESET  = 11'd210;

   localparam logic [SEC_W-1:0]  LAST_SECOND = 6'd59;
   localparam logic [MIN_W-1:0]  LAST_MINUTE = 6'd59;
   localparam logic [HOUR_W-1:0] LAST_HOUR   = 5'd23;

   // frame bit positions of the BCD time fields
   localparam int MIN_UNITS_LSB  = 21;
   localparam int MIN_TENS_LSB   = 25;
   localparam int HOUR_UNITS_LSB = 29;
   localparam int HOUR_TENS_LSB  = 33;

   typedef enum logic [2:0] {
      CSR_GAP_THRESHOLD = 3'd0,
      CSR_ZERO_LOW      = 3'd1,
      CSR_ZERO_HIGH     = 3'd2,
      CSR_ONE_LOW       = 3'd3,
      CSR_ONE_HIGH      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CNT_W-1:0] gap_threshold;
      logic [CNT_W-1:0] zero_low;
      logic [CNT_W-1:0] zero_high;
      logic [CNT_W-1:0] one_low;
      logic [CNT_W-1:0] one_high;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [MIN_W-1:0]  minutes;
      logic [HOUR_W-1:0] hours;
   } load_type;

   typedef struct packed {
      logic [SEC_W-1:0]  seconds;
      logic [MIN_W-1:0]  minutes;
      logic [HOUR_W-1:0] hours;
      logic              in_frame;
      logic              time_loaded;
   } rsp_type;

endpackage

[rtl/core/tspd_frame.sv]
// ----------------------------------------------------------------------------
// tspd_frame
// Interval timing, minute mark detection, bit classification, frame store
// and BCD decode of minutes and hours at the end of a frame.
// ----------------------------------------------------------------------------
module tspd_frame
   import tspd_pkg::*;
#(
   parameter int FRAME_LEN = 60
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  logic     level,
   input  cfg_type  cfg,
   output logic     active_next,
   output load_type load
);

   localparam int LAST_BIT = FRAME_LEN - 2;

   logic [CNT_W-1:0]     cnt_ff, cnt_in, cnt_inc;
   logic                 prev_ff, prev_in;
   logic                 active_ff, active_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [FRAME_LEN-1:0] store_ff, store_in;
   logic                 level_edge, is_zero, is_one, frame_end;
   logic [3:0]           min_units, hour_units;
   logic [2:0]           min_tens;
   logic [1:0]           hour_tens;
   logic [6:0]           min_value, hour_value;

   assign cnt_inc    = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
   assign level_edge = level != prev_ff;
   assign is_zero    = (cnt_inc > cfg.zero_low) && (cnt_inc < cfg.zero_high);
   assign is_one     = (cnt_inc > cfg.one_low) && (cnt_inc < cfg.one_high);

   always_comb begin
      cnt_in    = cnt_inc;
      prev_in   = level;
      active_in = active_ff;
      pos_in    = pos_ff;
      store_in  = store_ff;
      frame_end = 1'b0;
      if (level_edge) begin
         cnt_in = '0;
         if (!active_ff) begin
            if (cnt_inc > cfg.gap_threshold) begin
               active_in = 1'b1;
               pos_in    = '0;
            end
         end else if (is_zero || is_one) begin
            // a pulse fitting both windows counts as a one
            if (pos_ff < POS_W'(FRAME_LEN)) begin
               store_in[pos_ff] = is_one;
            end
            if (pos_ff >= POS_W'(LAST_BIT)) begin
               active_in = 1'b0;
               frame_end = 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   // BCD decode from the store as it stands after this item
   assign min_units  = store_in[MIN_UNITS_LSB +: 4];
   assign min_tens   = store_in[MIN_TENS_LSB +: 3];
   assign hour_units = store_in[HOUR_UNITS_LSB +: 4];
   assign hour_tens  = store_in[HOUR_TENS_LSB +: 2];
   assign min_value  = 7'(min_units) + 7'(min_tens) * 7'd10;
   assign hour_value = 7'(hour_units) + 7'(hour_tens) * 7'd10;

   assign load.valid   = frame_end && (min_value <= 7'(LAST_MINUTE))
                         && (hour_value <= 7'(LAST_HOUR));
   assign load.minutes = min_value[MIN_W-1:0];
   assign load.hours   = hour_value[HOUR_W-1:0];
   assign active_next  = active_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         prev_ff   <= 1'b0;
         active_ff <= 1'b0;
         pos_ff    <= '0;
         store_ff  <= '0;
      end else if (accept) begin
         cnt_ff    <= cnt_in;
         prev_ff   <= prev_in;
         active_ff <= active_in;
         pos_ff    <= pos_in;
         store_ff  <= store_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(LAST_BIT))
      else $error("bit position beyond last frame bit");

   a_load_ends_frame: assert property (@(posedge clock) disable iff (reset)
      accept && load.valid |=> !active_ff)
      else $error("frame still active after a load");

   a_mark_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      accept && !active_ff && active_in |=> pos_ff == '0 && cnt_ff == '0)
      else $error("frame start did not clear position and interval");

endmodule

[rtl/core/tspd_clock.sv]
// ----------------------------------------------------------------------------
// tspd_clock
// Local time of day: loads decoded minutes and hours, then advances by
// one second on the strobe with wrap of seconds, minutes and hours.
// ----------------------------------------------------------------------------
module tspd_clock
   import tspd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              strobe,
   input  load_type          load,
   output logic [SEC_W-1:0]  seconds_next,
   output logic [MIN_W-1:0]  minutes_next,
   output logic [HOUR_W-1:0] hours_next
);

   logic [SEC_W-1:0]  sec_ff, sec_in;
   logic [MIN_W-1:0]  min_ff, min_in, min_base;
   logic [HOUR_W-1:0] hour_ff, hour_in, hour_base;

   // load first, then advance
   assign min_base  = load.valid ? load.minutes : min_ff;
   assign hour_base = load.valid ? load.hours : hour_ff;

   always_comb begin
      sec_in  = sec_ff;
      min_in  = min_base;
      hour_in = hour_base;
      if (strobe) begin
         if (sec_ff >= LAST_SECOND) begin
            sec_in = '0;
            if (min_base >= LAST_MINUTE) begin
               min_in  = '0;
               hour_in = (hour_base >= LAST_HOUR) ? '0 : hour_base + 1'b1;
            end else begin
               min_in = min_base + 1'b1;
            end
         end else begin
            sec_in = sec_ff + 1'b1;
         end
      end
   end

   assign seconds_next = sec_in;
   assign minutes_next = min_in;
   assign hours_next   = hour_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff  <= '0;
         min_ff  <= '0;
         hour_ff <= '0;
      end else if (accept) begin
         sec_ff  <= sec_in;
         min_ff  <= min_in;
         hour_ff <= hour_in;
      end
   end

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      sec_ff <= LAST_SECOND && min_ff <= LAST_MINUTE && hour_ff <= LAST_HOUR)
      else $error("clock value out of range");

   a_load_keeps_seconds: assert property (@(posedge clock) disable iff (reset)
      accept && load.valid && !strobe |=> sec_ff == $past(sec_ff))
      else $error("load changed seconds");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(sec_ff) && $stable(min_ff) && $stable(hour_ff))
      else $error("clock moved without an item");

endmodule

[rtl/core/time_signal_pulse_decoder_clock_unit.sv]
// ----------------------------------------------------------------------------
// time_signal_pulse_decoder_clock_unit
// Millisecond-tick time-signal decoder with a local time-of-day clock.
// ----------------------------------------------------------------------------
// Each item is one millisecond tick carrying the sampled receiver level and a
// one-second strobe; every item yields one result with the clock time after
// that tick, the in-frame flag and a flag that is high when a decoded frame
// was loaded. Interval timing, pulse classification, BCD decode and the clock
// update sit between the state registers and the result register, so one item
// is accepted every cycle while the skid register is empty. A two-entry result
// buffer (result register plus skid register) keeps the input side accepting
// while one result waits; the input stalls only when both entries are full.
// Thresholds are written through the csr port while no item is in flight.
// ----------------------------------------------------------------------------
module time_signal_pulse_decoder_clock_unit
   import tspd_pkg::*;
#(
   parameter int FRAME_LEN = 60
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_signal_level,
   input  logic              req_second_strobe,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SEC_W-1:0]  rsp_seconds,
   output logic [MIN_W-1:0]  rsp_minutes,
   output logic [HOUR_W-1:0] rsp_hours,
   output logic              rsp_in_frame,
   output logic              rsp_time_loaded,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [CNT_W-1:0]  csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   rsp_type  out_ff, skid_ff, result;
   logic     out_valid_ff, skid_valid_ff;
   logic     accept, take;
   logic     active_next;
   load_type load;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAP_THRESHOLD: cfg_in.gap_threshold = csr_wdata;
            CSR_ZERO_LOW:      cfg_in.zero_low      = csr_wdata;
            CSR_ZERO_HIGH:     cfg_in.zero_high     = csr_wdata;
            CSR_ONE_LOW:       cfg_in.one_low       = csr_wdata;
            CSR_ONE_HIGH:      cfg_in.one_high      = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_threshold <= GAP_RESET;
         cfg_ff.zero_low      <= ZERO_LOW_RESET;
         cfg_ff.zero_high     <= ZERO_HIGH_RESET;
         cfg_ff.one_low       <= ONE_LOW_RESET;
         cfg_ff.one_high      <= ONE_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tspd_frame #(
      .FRAME_LEN(FRAME_LEN)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .level       (req_signal_level),
      .cfg         (cfg_ff),
      .active_next (active_next),
      .load        (load)
   );

   tspd_clock u_clock (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .strobe       (req_second_strobe),
      .load         (load),
      .seconds_next (result.seconds),
      .minutes_next (result.minutes),
      .hours_next   (result.hours)
   );

   assign result.in_frame    = active_next;
   assign result.time_loaded = load.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // drain the skid entry into the result register
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (out_valid_ff && !take) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_seconds     = out_ff.seconds;
   assign rsp_minutes     = out_ff.minutes;
   assign rsp_hours       = out_ff.hours;
   assign rsp_in_frame    = out_ff.in_frame;
   assign rsp_time_loaded = out_ff.time_loaded;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty result register");

   a_blocked_goes_to_skid: assert property (@(posedge clock) disable iff (reset)
      accept && out_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("item dropped while result was stalled");

   a_loaded_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_time_loaded |-> !rsp_in_frame)
      else $error("load reported inside a frame");

endmodule
